FILE: sv/ctl_pkg.sv
// Package of types, codes and sizes shared by the connection table lookup block.
package ctl_pkg;

   // Number of entries in the connection table.
   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   // Operation codes carried in the request.
   localparam logic [2:0] OP_ALLOC     = 3'd0;
   localparam logic [2:0] OP_FREE      = 3'd1;
   localparam logic [2:0] OP_INIT      = 3'd2;
   localparam logic [2:0] OP_SET_STATE = 3'd3;
   localparam logic [2:0] OP_FIND      = 3'd4;

   // Entry state codes.
   localparam logic [3:0] ENTRY_FREE   = 4'd0;
   localparam logic [3:0] ENTRY_ALLOC  = 4'd1;
   localparam logic [3:0] ENTRY_CLOSED = 4'd2;
   localparam logic [3:0] ENTRY_LISTEN = 4'd3;

   // Configuration register indexes.
   localparam logic CSR_UDP_CODE = 1'b0;
   localparam logic CSR_TCP_CODE = 1'b1;

   localparam logic [7:0] UDP_CODE_RESET = 8'd17;
   localparam logic [7:0] TCP_CODE_RESET = 8'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MODIFY,
      ST_SCAN
   } ctl_fsm_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [3:0]  entry_index;
      logic [7:0]  protocol_number;
      logic [31:0] remote_address;
      logic [15:0] remote_port_number;
      logic [31:0] local_address;
      logic [15:0] local_port_number;
      logic [3:0]  new_state;
   } ctl_req_type;

   typedef struct packed {
      logic       found;
      logic [3:0] result_index;
      logic [3:0] result_state;
   } ctl_rsp_type;

   typedef struct packed {
      logic [3:0]  state_code;
      logic [7:0]  protocol;
      logic [31:0] local_address;
      logic [15:0] local_port;
      logic [31:0] remote_address;
      logic [15:0] remote_port;
   } ctl_entry_type;

endpackage

FILE: sv/connection_table_lookup.sv
// Connection table lookup: a table of connection entries held in one synchronous memory.
//
// Usage. A request transfer takes place at a rising edge where start is high and busy is
// low; req_item carries the opcode, entry index, protocol and address/port tuple. Every
// request gives exactly one response transfer: rsp_strobe is high for one cycle with
// rsp_item, and the receiver cannot hold it off. busy stays high while a request is at
// work, so the next request may be offered in the cycle in which its response shows.
// Operation. Free, init tuple and set state do a read-modify-write of one entry: the
// entry is read as the request is taken and written back from ST_MODIFY, which also
// registers the response. Unused opcodes, an entry index beyond the table and an alloc
// of an unknown protocol answer in the next cycle. Alloc and find walk the table in
// index order, one entry read from memory per cycle, and stop at the first hit, or
// answer a miss after the last entry. The memory read port sets the pace of a scan; no
// new request is taken while one is at work.
// Reset. A synchronous active-high reset marks every entry as never written, so it reads
// as all zero (free) with no clearing pass, and returns the protocol registers to 17
// (datagram) and 6 (stream). csr_ writes take effect at once and must be made only
// while the block is idle; the block itself does not enforce this.
module connection_table_lookup (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ctl_pkg::ctl_req_type req_item,
   output logic                 rsp_strobe,
   output ctl_pkg::ctl_rsp_type rsp_item,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [7:0]           csr_write_data
);
   import ctl_pkg::*;

   localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(TABLE_ENTRIES - 1);

   // Table storage, and one valid flag per entry so that reset empties the table at once.
   ctl_entry_type      table_mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;

   ctl_fsm_type        state_ff, state_in;
   ctl_req_type        req_ff;
   logic [3:0]         code_ff, code_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   ctl_entry_type      rd_data_ff;
   logic               rd_valid_ff;
   logic [7:0]         udp_code_ff, tcp_code_ff;
   logic               rsp_strobe_ff, rsp_strobe_in;
   ctl_rsp_type        rsp_ff, rsp_in;

   logic               accept;
   logic               in_table;
   logic               is_udp, is_tcp;
   logic               scan_op, modify_op;
   logic [IDX_W-1:0]   rd_addr;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   ctl_entry_type      mem_wdata;
   ctl_entry_type      entry;
   logic               local_ok, full_ok, listen_ok;
   logic               is_alloc, hit;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // Decode of the request offered on the ports.
   assign in_table  = 32'(req_item.entry_index) < 32'(TABLE_ENTRIES);
   assign is_udp    = (req_item.protocol_number == udp_code_ff);
   assign is_tcp    = (req_item.protocol_number == tcp_code_ff);
   assign scan_op   = ((req_item.opcode == OP_ALLOC) && (is_udp || is_tcp)) ||
                      (req_item.opcode == OP_FIND);
   assign modify_op = ((req_item.opcode == OP_FREE) || (req_item.opcode == OP_INIT) ||
                       (req_item.opcode == OP_SET_STATE)) && in_table;
   // A datagram match wins where both registers hold the same protocol.
   assign code_in   = is_udp ? ENTRY_ALLOC : ENTRY_CLOSED;

   // An entry that was never written since reset reads as all zero.
   assign entry = rd_valid_ff ? rd_data_ff : '0;

   // Match logic for the entry that the memory delivered this cycle.
   assign local_ok  = (entry.local_address == req_ff.local_address) &&
                      (entry.local_port == req_ff.local_port_number) &&
                      (entry.protocol == req_ff.protocol_number);
   assign full_ok   = local_ok && (entry.remote_address == req_ff.remote_address) &&
                      (entry.remote_port == req_ff.remote_port_number) &&
                      (entry.state_code != ENTRY_FREE);
   assign listen_ok = local_ok && (entry.state_code == ENTRY_LISTEN);
   assign is_alloc  = (req_ff.opcode == OP_ALLOC);
   assign hit       = is_alloc ? (entry.state_code == ENTRY_FREE) : (full_ok || listen_ok);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (scan_op) begin
                  state_in = ST_SCAN;
               end else if (modify_op) begin
                  state_in = ST_MODIFY;
               end
            end
         end
         ST_MODIFY: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (hit || (cnt_ff == LAST_ENTRY)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory addressing, write-back and response.
   always_comb begin
      rd_addr       = IDX_W'(req_item.entry_index);
      cnt_in        = cnt_ff;
      mem_we        = 1'b0;
      mem_waddr     = cnt_ff;
      mem_wdata     = entry;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in = '0;
               if (scan_op) begin
                  rd_addr = '0;
               end else if (!modify_op) begin
                  // Nothing to do in the table: answer with an all-zero response.
                  rsp_strobe_in = 1'b1;
               end
            end
         end
         ST_MODIFY: begin
            mem_we        = 1'b1;
            mem_waddr     = IDX_W'(req_ff.entry_index);
            rsp_strobe_in = 1'b1;
            case (req_ff.opcode)
               OP_FREE: begin
                  mem_wdata.state_code = ENTRY_FREE;
               end
               OP_INIT: begin
                  mem_wdata.remote_address = req_ff.remote_address;
                  mem_wdata.remote_port    = req_ff.remote_port_number;
                  mem_wdata.local_address  = req_ff.local_address;
                  mem_wdata.local_port     = req_ff.local_port_number;
               end
               OP_SET_STATE: begin
                  mem_wdata.state_code = req_ff.new_state;
               end
               default: begin
                  mem_we = 1'b0;
               end
            endcase
         end
         ST_SCAN: begin
            rd_addr = cnt_ff + 1'b1;
            cnt_in  = cnt_ff + 1'b1;
            if (hit) begin
               rsp_strobe_in       = 1'b1;
               rsp_in.found        = 1'b1;
               rsp_in.result_index = 4'(cnt_ff);
               if (is_alloc) begin
                  rsp_in.result_state  = code_ff;
                  mem_we               = 1'b1;
                  mem_wdata.state_code = code_ff;
                  mem_wdata.protocol   = req_ff.protocol_number;
               end else begin
                  rsp_in.result_state = entry.state_code;
               end
            end else if (cnt_ff == LAST_ENTRY) begin
               rsp_strobe_in = 1'b1;
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // Table memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         udp_code_ff   <= UDP_CODE_RESET;
         tcp_code_ff   <= TCP_CODE_RESET;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= valid_ff[rd_addr];
         rsp_strobe_ff <= rsp_strobe_in;
         if (mem_we) begin
            valid_ff[mem_waddr] <= 1'b1;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_UDP_CODE: udp_code_ff <= csr_write_data;
               CSR_TCP_CODE: tcp_code_ff <= csr_write_data;
               default: begin
                  udp_code_ff <= udp_code_ff;
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff  <= req_item;
         code_ff <= code_in;
      end
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // A response is only ever shown once the block has gone back to idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (state_ff == ST_IDLE))
      else $error("response shown while a request is still at work");

   // Every accepted request either answers in the next cycle or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_strobe_ff || (state_ff != ST_IDLE)))
      else $error("accepted request neither answered nor in progress");

   // The table is written only while a request is at work.
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff != ST_IDLE))
      else $error("table written while idle");

   // A successful alloc or find always reports an entry that is in use.
   a_found_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.found) |-> (rsp_ff.result_state != ENTRY_FREE))
      else $error("hit reported on a free entry");

   // The scan never runs past the end of the table.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && (cnt_ff == LAST_ENTRY)) |=> (state_ff == ST_IDLE))
      else $error("scan ran past the last entry");

endmodule

FILE: sim/ctl_lookup_checker.sv
// Checker that predicts the answers of the connection table lookup and compares each response.
module ctl_lookup_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  ctl_pkg::ctl_req_type req_item,
   input  logic                 rsp_strobe,
   input  ctl_pkg::ctl_rsp_type rsp_item,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [7:0]           csr_write_data,
   output int unsigned          failures,
   output int unsigned          pending
);
   import ctl_pkg::*;

   ctl_entry_type conn_table [TABLE_ENTRIES];
   logic [7:0]    datagram_code;
   logic [7:0]    stream_code;
   ctl_rsp_type   answers_due [$];
   int unsigned   mismatch_count = 0;

   assign failures = mismatch_count;

   // Applies one request to the shadow table and returns the answer it should give.
   function automatic ctl_rsp_type predict_answer(input ctl_req_type r);
      ctl_rsp_type answer;
      logic [3:0]  claim_code;
      logic        local_ok;
      answer = '0;
      case (r.opcode)
         OP_ALLOC: begin
            if (r.protocol_number == datagram_code)
               claim_code = ENTRY_ALLOC;
            else if (r.protocol_number == stream_code)
               claim_code = ENTRY_CLOSED;
            else
               return answer;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (conn_table[i].state_code == ENTRY_FREE) begin
                  conn_table[i].state_code = claim_code;
                  conn_table[i].protocol   = r.protocol_number;
                  answer.found        = 1'b1;
                  answer.result_index = 4'(i);
                  answer.result_state = claim_code;
                  return answer;
               end
            end
         end
         OP_FREE: begin
            if (int'(r.entry_index) < TABLE_ENTRIES)
               conn_table[r.entry_index].state_code = ENTRY_FREE;
         end
         OP_INIT: begin
            if (int'(r.entry_index) < TABLE_ENTRIES) begin
               conn_table[r.entry_index].remote_address = r.remote_address;
               conn_table[r.entry_index].remote_port    = r.remote_port_number;
               conn_table[r.entry_index].local_address  = r.local_address;
               conn_table[r.entry_index].local_port     = r.local_port_number;
            end
         end
         OP_SET_STATE: begin
            if (int'(r.entry_index) < TABLE_ENTRIES)
               conn_table[r.entry_index].state_code = r.new_state;
         end
         OP_FIND: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               local_ok = conn_table[i].local_address == r.local_address &&
                          conn_table[i].local_port == r.local_port_number &&
                          conn_table[i].protocol == r.protocol_number;
               if (local_ok && ((conn_table[i].state_code != ENTRY_FREE &&
                                 conn_table[i].remote_address == r.remote_address &&
                                 conn_table[i].remote_port == r.remote_port_number) ||
                                conn_table[i].state_code == ENTRY_LISTEN)) begin
                  answer.found        = 1'b1;
                  answer.result_index = 4'(i);
                  answer.result_state = conn_table[i].state_code;
                  return answer;
               end
            end
         end
         default: ;
      endcase
      return answer;
   endfunction

   task automatic note_mismatch(input string what, input ctl_rsp_type want,
                                input ctl_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: expected found=%0b index=%0d state=%0d, got found=%0b index=%0d state=%0d",
                  $realtime, what, want.found, want.result_index, want.result_state,
                  got.found, got.result_index, got.result_state);
   endtask

   always @(posedge clock) begin : watch
      ctl_rsp_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++)
            conn_table[i] = '0;
         datagram_code = UDP_CODE_RESET;
         stream_code   = TCP_CODE_RESET;
         answers_due.delete();
      end else begin
         if (rsp_strobe) begin
            if (answers_due.size() == 0) begin
               note_mismatch("unexpected response", '0, rsp_item);
            end else begin
               want = answers_due.pop_front();
               if (want.found !== rsp_item.found ||
                   want.result_index !== rsp_item.result_index ||
                   want.result_state !== rsp_item.result_state)
                  note_mismatch("wrong response", want, rsp_item);
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_UDP_CODE)
               datagram_code = csr_write_data;
            else
               stream_code = csr_write_data;
         end
         if (start && !busy)
            answers_due.push_back(predict_answer(req_item));
      end
      pending <= answers_due.size();
   end

endmodule

FILE: sim/tb_connection_table_lookup.sv
// Testbench top for the connection table lookup: clock, reset, stimulus and final verdict.
module tb_connection_table_lookup;
   import ctl_pkg::*;

   // Opcodes the block does not define; they must change nothing and answer all zero.
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   localparam int TUPLES         = 4;
   localparam int PHASES         = 5;
   localparam int ITEMS_PER_PHASE = 110;
   // The slowest correct run stays well under this limit, which leaves a wide margin.
   localparam int CYCLE_LIMIT    = 200000;

   // An address and port tuple, kept apart from the request so that a small pool of them
   // can be shared between init and find requests and lookups actually hit.
   typedef struct packed {
      logic [31:0] remote_address;
      logic [15:0] remote_port;
      logic [31:0] local_address;
      logic [15:0] local_port;
   } conn_tuple_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        start            = 1'b0;
   ctl_req_type req_item         = '0;
   logic        csr_write_enable = 1'b0;
   logic        csr_index        = CSR_UDP_CODE;
   logic [7:0]  csr_write_data   = '0;
   logic        busy;
   logic        rsp_strobe;
   ctl_rsp_type rsp_item;

   int unsigned mismatch_total;
   int unsigned answers_outstanding;
   int unsigned cycle_count = 0;

   // The protocol codes the block currently holds, so that most requests use them.
   logic [7:0]     udp_now = UDP_CODE_RESET;
   logic [7:0]     tcp_now = TCP_CODE_RESET;
   conn_tuple_type tuple_pool [TUPLES];
   // When set, the sender offers requests back to back with no idle cycles.
   bit             steady = 1'b0;

   connection_table_lookup u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_item         (req_item),
      .rsp_strobe       (rsp_strobe),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   ctl_lookup_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_item         (req_item),
      .rsp_strobe       (rsp_strobe),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .failures         (mismatch_total),
      .pending          (answers_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost response must not keep the run going for ever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic ctl_req_type make_request(input logic [2:0] op, input logic [3:0] slot,
                                                input logic [7:0] proto, input conn_tuple_type t,
                                                input logic [3:0] code);
      ctl_req_type r;
      r.opcode             = op;
      r.entry_index        = slot;
      r.protocol_number    = proto;
      r.remote_address     = t.remote_address;
      r.remote_port_number = t.remote_port;
      r.local_address      = t.local_address;
      r.local_port_number  = t.local_port;
      r.new_state          = code;
      return r;
   endfunction

   // Random request. Most of the traffic uses the live protocol codes and the shared tuple
   // pool, so that allocations succeed and finds hit; the rest is noise that exercises the
   // miss paths, unknown protocols, meaningless state codes and the spare opcodes.
   function automatic ctl_req_type random_request();
      int unsigned    roll;
      logic [2:0]     op;
      logic [7:0]     proto;
      conn_tuple_type t;
      roll = $urandom_range(99);
      if (roll < 24)
         op = OP_ALLOC;
      else if (roll < 38)
         op = OP_FREE;
      else if (roll < 54)
         op = OP_INIT;
      else if (roll < 64)
         op = OP_SET_STATE;
      else if (roll < 94)
         op = OP_FIND;
      else
         op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
      roll = $urandom_range(99);
      if (roll < 45)
         proto = udp_now;
      else if (roll < 85)
         proto = tcp_now;
      else
         proto = 8'($urandom);
      if ($urandom_range(99) < 80)
         t = tuple_pool[$urandom_range(TUPLES - 1)];
      else
         t = {$urandom, 16'($urandom), $urandom, 16'($urandom)};
      // A find whose remote half matches nothing can only hit a listening entry.
      if (op == OP_FIND && $urandom_range(99) < 25) begin
         t.remote_address = $urandom;
         t.remote_port    = 16'($urandom);
      end
      return make_request(op, 4'($urandom), proto, t,
                          ($urandom_range(99) < 60) ? 4'($urandom_range(ENTRY_LISTEN))
                                                    : 4'($urandom));
   endfunction

   // Offers one request and returns at the rising edge where the transfer took place, with
   // start still high so that the next request can follow without a gap. busy only changes
   // at a rising edge, so its value at the falling edge is the one the next edge will see.
   task automatic offer_request(input ctl_req_type r);
      logic taken;
      while (!steady && $urandom_range(99) < 38) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end
   endtask

   // Stops offering, waits for every outstanding response and then lets the block settle
   // for longer than its slowest lookup takes. Returns aligned to a rising edge.
   task automatic drain_block();
      start <= 1'b0;
      @(negedge clock);
      while (answers_outstanding != 0)
         @(negedge clock);
      repeat (TABLE_ENTRIES + 4) @(posedge clock);
   endtask

   // Writes both protocol registers on consecutive cycles; only called while idle.
   task automatic program_codes(input logic [7:0] datagram, input logic [7:0] stream);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_UDP_CODE;
      csr_write_data   <= datagram;
      @(posedge clock);
      csr_index        <= CSR_TCP_CODE;
      csr_write_data   <= stream;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      udp_now = datagram;
      tcp_now = stream;
   endtask

   initial begin
      conn_tuple_type zero_t;
      conn_tuple_type ones_t;
      conn_tuple_type listen_t;
      logic [7:0]     shared_code;
      int unsigned    sent;
      zero_t = '0;
      ones_t = '1;
      // The pool holds the two extreme tuples and a couple of random ones.
      tuple_pool[0] = zero_t;
      tuple_pool[1] = ones_t;
      for (int k = 2; k < TUPLES; k++)
         tuple_pool[k] = {$urandom, 16'($urandom), $urandom, 16'($urandom)};
      listen_t = tuple_pool[2];
      listen_t.remote_address = ~listen_t.remote_address;
      listen_t.remote_port    = ~listen_t.remote_port;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with the protocol codes as they come out of reset.
      // A cleared entry matches the all-zero tuple on protocol zero, but it is free.
      offer_request(make_request(OP_FIND, 4'h0, 8'h00, zero_t, ENTRY_FREE));
      offer_request(make_request(OP_ALLOC, 4'h0, UDP_CODE_RESET, zero_t, ENTRY_FREE));
      offer_request(make_request(OP_ALLOC, 4'hF, TCP_CODE_RESET, ones_t, ENTRY_LISTEN));
      // Protocols that are neither datagram nor stream must fail to allocate.
      offer_request(make_request(OP_ALLOC, 4'h0, 8'hFF, ones_t, 4'hF));
      offer_request(make_request(OP_ALLOC, 4'hF, 8'h00, zero_t, ENTRY_FREE));
      offer_request(make_request(OP_INIT, 4'h0, 8'h00, ones_t, ENTRY_FREE));
      offer_request(make_request(OP_FIND, 4'h0, UDP_CODE_RESET, ones_t, ENTRY_FREE));
      // Right tuple, wrong protocol: a miss.
      offer_request(make_request(OP_FIND, 4'h0, TCP_CODE_RESET, ones_t, ENTRY_FREE));
      // The stream entry kept its all-zero tuple, so a full match on it is a hit.
      offer_request(make_request(OP_FIND, 4'h0, TCP_CODE_RESET, zero_t, ENTRY_FREE));
      // A listening entry matches on its local half alone.
      offer_request(make_request(OP_INIT, 4'h1, 8'hFF, tuple_pool[2], 4'hF));
      offer_request(make_request(OP_SET_STATE, 4'h1, 8'h00, zero_t, ENTRY_LISTEN));
      offer_request(make_request(OP_FIND, 4'hF, TCP_CODE_RESET, listen_t, ENTRY_FREE));
      // Set state accepts a code with no meaning, here in the last entry of the table.
      offer_request(make_request(OP_SET_STATE, 4'hF, 8'hFF, ones_t, 4'hF));
      offer_request(make_request(OP_FIND, 4'h0, 8'h00, zero_t, ENTRY_FREE));
      // Freeing and reallocating entry zero must keep its tuple.
      offer_request(make_request(OP_FREE, 4'h0, 8'h00, zero_t, ENTRY_FREE));
      offer_request(make_request(OP_FIND, 4'h0, UDP_CODE_RESET, ones_t, ENTRY_FREE));
      offer_request(make_request(OP_ALLOC, 4'h0, UDP_CODE_RESET, zero_t, ENTRY_FREE));
      offer_request(make_request(OP_FIND, 4'h0, UDP_CODE_RESET, ones_t, ENTRY_FREE));
      for (int k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++)
         offer_request(make_request(3'(k), 4'hF, 8'hFF, ones_t, 4'hF));
      offer_request(make_request(OP_FREE, 4'hF, 8'hFF, ones_t, 4'hF));
      offer_request(make_request(OP_SET_STATE, 4'h0, 8'h00, zero_t, ENTRY_FREE));

      // Random part, in phases with different protocol codes. Each phase starts with the
      // block idle. The fourth phase sets both codes equal, where datagram must win.
      sent = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_block();
         case (phase)
            0: program_codes(UDP_CODE_RESET, TCP_CODE_RESET);
            1: program_codes(8'h00, 8'hFF);
            2: program_codes(8'hFF, 8'h00);
            3: begin
               shared_code = 8'($urandom);
               program_codes(shared_code, shared_code);
            end
            default: program_codes(8'($urandom), 8'($urandom));
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            steady = (sent >= 60 && sent < 140);
            offer_request(random_request());
            sent++;
         end
      end

      drain_block();
      if (mismatch_total == 0 && answers_outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
sv/ctl_pkg.sv
sv/connection_table_lookup.sv
sim/ctl_lookup_checker.sv
sim/tb_connection_table_lookup.sv
